// ----- hw/rtl/mcpg_pkg.sv -----
// ============================================================================
// mcpg_pkg
// Shared types and constants for the midpoint circle point generator.
// ============================================================================
package mcpg_pkg;

  localparam int unsigned CoordW = 11;   // center coordinates, x offset
  localparam int unsigned RadW   = 10;   // radius
  localparam int unsigned OffYW  = 12;   // y offset, two's complement
  localparam int unsigned DecW   = 14;   // decision value, two's complement
  localparam int unsigned PointW = 13;   // emitted coordinates, two's complement

  localparam int unsigned PtsPerStep = 16;
  localparam int unsigned IdxW       = $clog2(PtsPerStep);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PtsPerStep - 1);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  // One step's work: the center and the offsets before and after the update.
  typedef struct packed {
    logic [CoordW-1:0]       cen_x;
    logic [CoordW-1:0]       cen_y;
    logic [CoordW-1:0]       x0;
    logic signed [OffYW-1:0] y0;
    logic [CoordW-1:0]       x1;
    logic signed [OffYW-1:0] y1;
    logic                    done;
  } job_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic mid_step;   // some points of the head job already emitted
  } back_stat_t;

endpackage

// ----- hw/rtl/mcpg_front.sv -----
// ============================================================================
// mcpg_front
// Accepts commands, holds the circle state and computes one loop pass per
// step, handing the result to the queue.
// ============================================================================
module mcpg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        cmd_i,
  input  logic [mcpg_pkg::CoordW-1:0] center_x_i,
  input  logic [mcpg_pkg::CoordW-1:0] center_y_i,
  input  logic [mcpg_pkg::RadW-1:0]   radius_i,
  output logic                        push_o,
  output mcpg_pkg::job_t              job_o
);
  import mcpg_pkg::*;

  logic [CoordW-1:0]       cen_x_q, cen_x_d;
  logic [CoordW-1:0]       cen_y_q, cen_y_d;
  logic [CoordW-1:0]       off_x_q, off_x_d;
  logic signed [OffYW-1:0] off_y_q, off_y_d;
  logic signed [DecW-1:0]  dec_q, dec_d;
  logic                    active_q, active_d;

  logic                    accept;
  logic [CoordW-1:0]       x_inc;
  logic signed [OffYW-1:0] y_new;
  logic signed [DecW-1:0]  dec_new;
  logic [DecW-1:0]         dx, dy;
  logic                    d_pos;
  logic                    done;

  assign accept = in_valid_i && in_ready_i;

  // One loop pass on the current state.
  always_comb begin
    d_pos   = (dec_q > 0);
    x_inc   = off_x_q + CoordW'(1);
    y_new   = d_pos ? (off_y_q - OffYW'(1)) : off_y_q;
    dx      = {{(DecW-CoordW){1'b0}}, x_inc};
    dy      = {{(DecW-OffYW){y_new[OffYW-1]}}, y_new};
    if (d_pos) begin
      dec_new = dec_q + $signed((dx - dy) << 2) + DecW'(10);
    end else begin
      dec_new = dec_q + $signed(dx << 2) + DecW'(6);
    end
    done = ($signed({y_new[OffYW-1], y_new}) < $signed({2'b00, x_inc}));
  end

  always_comb begin
    cen_x_d  = cen_x_q;
    cen_y_d  = cen_y_q;
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;
    dec_d    = dec_q;
    active_d = active_q;
    push_o   = 1'b0;
    if (accept) begin
      unique case (cmd_i)
        CmdStart: begin
          cen_x_d  = center_x_i;
          cen_y_d  = center_y_i;
          off_x_d  = '0;
          off_y_d  = $signed({{(OffYW-RadW){1'b0}}, radius_i});
          dec_d    = $signed(DecW'(3) - {{(DecW-RadW-1){1'b0}}, radius_i, 1'b0});
          active_d = 1'b1;
        end
        CmdStep: begin
          if (active_q) begin
            push_o   = 1'b1;
            off_x_d  = x_inc;
            off_y_d  = y_new;
            dec_d    = dec_new;
            active_d = !done;
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_comb begin
    job_o.cen_x = cen_x_q;
    job_o.cen_y = cen_y_q;
    job_o.x0    = off_x_q;
    job_o.y0    = off_y_q;
    job_o.x1    = x_inc;
    job_o.y1    = y_new;
    job_o.done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_x_q  <= '0;
      cen_y_q  <= '0;
      off_x_q  <= '0;
      off_y_q  <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cen_x_q  <= cen_x_d;
      cen_y_q  <= cen_y_d;
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
    end
  end

endmodule

// ----- hw/rtl/mcpg_queue.sv -----
// ============================================================================
// mcpg_queue
// Short job queue between the front end and the point emitter.
// ============================================================================
module mcpg_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  mcpg_pkg::job_t             job_i,
  input  logic                       pop_i,
  output logic                       full_o,
  output logic                       valid_o,
  output mcpg_pkg::job_t             job_o,
  output logic [mcpg_pkg::QCntW-1:0] count_o
);
  import mcpg_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    ptr_next = (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/mcpg_back.sv -----
// ============================================================================
// mcpg_back
// Walks the sixteen symmetric points of the head job into the output
// register, one per cycle unless the receiver stalls.
// ============================================================================
module mcpg_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  mcpg_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mcpg_pkg::PointW-1:0] point_x_o,
  output logic signed [mcpg_pkg::PointW-1:0] point_y_o,
  output logic                               last_of_step_o,
  output logic                               circle_done_o,
  output mcpg_pkg::back_stat_t               stat_o
);
  import mcpg_pkg::*;

  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [PointW-1:0] px_q, px_d;
  logic [PointW-1:0] py_q, py_d;
  logic              last_q, last_d;
  logic              done_q, done_d;

  logic              load;
  logic [PointW-1:0] ox, oy, a, b, cx, cy;
  logic [CoordW-1:0] sel_x;
  logic [OffYW-1:0]  sel_y;

  assign load  = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (idx_q == LastIdx);

  // Upper half uses the updated offsets; bit 2 swaps the roles of x and y,
  // bit 1 negates the row term, bit 0 the column term.
  always_comb begin
    sel_x = idx_q[3] ? job_i.x1 : job_i.x0;
    sel_y = idx_q[3] ? job_i.y1 : job_i.y0;
    ox    = {{(PointW-CoordW){1'b0}}, sel_x};
    oy    = {{(PointW-OffYW){sel_y[OffYW-1]}}, sel_y};
    a     = idx_q[2] ? oy : ox;
    b     = idx_q[2] ? ox : oy;
    cx    = {{(PointW-CoordW){1'b0}}, job_i.cen_x};
    cy    = {{(PointW-CoordW){1'b0}}, job_i.cen_y};
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    done_d      = done_q;
    if (load) begin
      idx_d       = idx_q + IdxW'(1);
      out_valid_d = 1'b1;
      px_d        = idx_q[0] ? (cx - a) : (cx + a);
      py_d        = idx_q[1] ? (cy - b) : (cy + b);
      last_d      = (idx_q == LastIdx);
      done_d      = job_i.done;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign point_x_o       = $signed(px_q);
  assign point_y_o       = $signed(py_q);
  assign last_of_step_o  = last_q;
  assign circle_done_o   = done_q;
  assign stat_o.mid_step = (idx_q != '0);

endmodule

// ----- hw/rtl/midpoint_circle_point_generator.sv -----
// ============================================================================
// midpoint_circle_point_generator
// Midpoint circle rasterizer with eightfold symmetry, one pixel per beat.
// ============================================================================
// Input channel (in_valid_i / in_ready_o) takes command beats. A start beat
// (cmd_i = 0) latches center_x_i, center_y_i and radius_i and emits nothing.
// A step beat (cmd_i = 1) while a circle is in progress produces sixteen
// output beats: the eight mirror points of the current offsets, then the
// eight of the updated offsets. last_of_step_o marks the sixteenth beat and
// circle_done_o is high on all sixteen beats of the step that ends the
// circle. A step while no circle is in progress is taken and dropped.
// The first point of a step appears once its job has passed the queue and
// been loaded into the output register, when the emitter is free.
// Throughput: one point per cycle unless the receiver stalls; the emitter
// walking the sixteen points of a queued step sets this figure. Start beats
// and dropped steps push no job and overlap with emission.
// The front end computes each step on acceptance and parks it in a two-entry
// queue. The step being emitted stays at the queue head until its last point
// is loaded, so one more step may wait behind it; in_ready_o drops only while
// the queue is full.
// Reset clears the circle state (idle) and empties the queue. When the
// receiver stalls, hold the current point; the queue then fills and
// back-pressures the input.
// ============================================================================
module midpoint_circle_point_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [mcpg_pkg::CoordW-1:0]        center_x_i,
  input  logic [mcpg_pkg::CoordW-1:0]        center_y_i,
  input  logic [mcpg_pkg::RadW-1:0]          radius_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mcpg_pkg::PointW-1:0] point_x_o,
  output logic signed [mcpg_pkg::PointW-1:0] point_y_o,
  output logic                               last_of_step_o,
  output logic                               circle_done_o
);
  import mcpg_pkg::*;

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_valid;
  logic [QCntW-1:0] q_count;
  job_t             job_in;
  job_t             job_head;
  back_stat_t       back_stat;

  // Accept while the queue has room; every command is taken on that basis.
  assign in_ready_o = !q_full;

  // Front end: classify commands, advance the circle state.
  mcpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .cmd_i      (cmd_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .push_o     (push),
    .job_o      (job_in)
  );

  // Decouple the two sides.
  mcpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (job_head),
    .count_o (q_count)
  );

  // Back end: emit the sixteen points of the head job.
  mcpg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (job_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o),
    .stat_o         (back_stat)
  );

  // No push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("job pushed into full queue");

  // A partly emitted step keeps its job at the queue head.
  a_mid_step_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.mid_step |-> (q_count != '0))
    else $error("step in progress without a queued job");

  // Points of one step follow without a gap and share the done flag.
  a_step_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_step_o)
      |=> (out_valid_o && $stable(circle_done_o)))
    else $error("gap or done change inside a step");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: midpoint circle point generator bench
// Sends start and step commands, some directed and most as random circles.
// It predicts the sixteen mirror points of every traced step and compares each
// output beat against them in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcpg_pkg::*;

  localparam int QuietTail  = 30;    // last commands are sent with no idling
  localparam int StallLimit = 1000;  // cycles with no beat on either side
  localparam int ErrShown   = 10;

  // One command as the sender holds it. Set hold_for_drain to make the sender
  // wait until every predicted point has come out before presenting it.
  typedef struct {
    logic              cmd;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [RadW-1:0]   r;
    bit                hold_for_drain;
  } circle_cmd_t;

  typedef struct packed {
    logic signed [PointW-1:0] px;
    logic signed [PointW-1:0] py;
    logic                     last;
    logic                     done;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic              cmd = CmdStart;
  logic [CoordW-1:0] center_x = '0;
  logic [CoordW-1:0] center_y = '0;
  logic [RadW-1:0]   radius = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic signed [PointW-1:0] point_x_o;
  logic signed [PointW-1:0] point_y_o;
  logic              last_of_step_o;
  logic              circle_done_o;

  // Commands waiting to be sent, and the points predicted but not yet seen.
  circle_cmd_t cmd_q[$];
  pixel_t      pixel_q[$];

  // Predictor state: a private copy of the circle registers.
  logic [CoordW-1:0]       cen_x_m = '0;
  logic [CoordW-1:0]       cen_y_m = '0;
  logic [CoordW-1:0]       off_x_m = '0;
  logic signed [OffYW-1:0] off_y_m = '0;
  logic signed [DecW-1:0]  dec_m = '0;
  logic                    tracing_m = 1'b0;

  int err_cnt = 0;
  int n_points = 0;
  int n_starts = 0;
  int n_steps = 0;
  int n_idle_steps = 0;
  int n_circles = 0;
  int quiet_cycles = 0;

  midpoint_circle_point_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd),
    .center_x_i    (center_x),
    .center_y_i    (center_y),
    .radius_i      (radius),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o (circle_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle only while enough commands remain; the tail runs at full rate.
  function automatic bit bursts_on();
    return cmd_q.size() >= QuietTail;
  endfunction

  task automatic add_cmd(input logic c, input int cx, input int cy, input int r,
                         input bit hold);
    circle_cmd_t it;
    it.cmd = c;
    it.cx = CoordW'(cx);
    it.cy = CoordW'(cy);
    it.r = RadW'(r);
    it.hold_for_drain = hold;
    cmd_q.push_back(it);
  endtask

  // Queue the eight mirror points of offsets (x,y) around the latched center.
  // Order: (+x,+y) (-x,+y) (+x,-y) (-x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x).
  task automatic push_octants(input int x, input int y, input logic done,
                              input logic closes);
    int     cx;
    int     cy;
    int     a;
    int     b;
    int     k;
    pixel_t p;
    cx = int'(cen_x_m);
    cy = int'(cen_y_m);
    for (k = 0; k < 8; k++) begin
      a = (k < 4) ? x : y;
      b = (k < 4) ? y : x;
      p.px = PointW'(cx + ((k % 2 == 0) ? a : -a));
      p.py = PointW'(cy + ((k % 4 < 2) ? b : -b));
      p.last = closes && (k == 7);
      p.done = done;
      pixel_q.push_back(p);
    end
  endtask

  // Advance the predicted circle by one accepted command.
  task automatic trace_circle_cmd(input circle_cmd_t it);
    int   x0;
    int   y0;
    int   x1;
    int   y1;
    logic done;
    if (it.cmd == CmdStart) begin
      // Load the center, put the walk at the top of the circle, seed 3 - 2r.
      cen_x_m = it.cx;
      cen_y_m = it.cy;
      off_x_m = '0;
      off_y_m = OffYW'(int'(it.r));
      dec_m = DecW'(3 - 2 * int'(it.r));
      tracing_m = 1'b1;
      n_starts++;
    end else if (!tracing_m) begin
      // Drop: a step with no circle in progress produces nothing.
      n_idle_steps++;
    end else begin
      x0 = int'(off_x_m);
      y0 = int'(off_y_m);
      off_x_m = CoordW'(x0 + 1);
      x1 = int'(off_x_m);
      if (dec_m > 0) begin
        // Midpoint outside the circle: step y inward as well.
        off_y_m = OffYW'(y0 - 1);
        y1 = int'(off_y_m);
        dec_m = DecW'(int'(dec_m) + 4 * (x1 - y1) + 10);
      end else begin
        y1 = y0;
        dec_m = DecW'(int'(dec_m) + 4 * x1 + 6);
      end
      done = (y1 < x1);
      push_octants(x0, y0, done, 1'b0);
      push_octants(x1, y1, done, 1'b1);
      if (done) begin
        tracing_m = 1'b0;
        n_circles++;
      end
      n_steps++;
    end
  endtask

  // Sender: hold each beat until accepted, then present the next one or
  // insert an idle burst.
  circle_cmd_t cur_cmd;
  int          gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        trace_circle_cmd(cur_cmd);
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bursts_on() && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0 &&
                     !(cmd_q[0].hold_for_drain && pixel_q.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          cmd <= cur_cmd.cmd;
          center_x <= cur_cmd.cx;
          center_y <= cur_cmd.cy;
          radius <= cur_cmd.r;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check every accepted point against the oldest prediction, and
  // stall ready in random bursts.
  pixel_t want;
  int     stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_points++;
        if (pixel_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ErrShown)
            $display("unexpected point (%0d,%0d) last %0b done %0b",
                     point_x_o, point_y_o, last_of_step_o, circle_done_o);
        end else begin
          want = pixel_q.pop_front();
          if (point_x_o !== want.px || point_y_o !== want.py ||
              last_of_step_o !== want.last || circle_done_o !== want.done) begin
            err_cnt++;
            if (err_cnt <= ErrShown) begin
              $display("point %0d: expected (%0d,%0d) last %0b done %0b",
                       n_points, want.px, want.py, want.last, want.done);
              $display("point %0d: got      (%0d,%0d) last %0b done %0b",
                       n_points, point_x_o, point_y_o, last_of_step_o,
                       circle_done_o);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (bursts_on() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d points pending",
                 quiet_cycles, pixel_q.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int r;
    int cx;
    int cy;
    int full;
    int nsteps;
    int sel;
    int seq;
    int made;
    int i;

    // Directed: a step with no circle, zero radius, the far corner with the
    // largest radius, a start that abandons a running circle, small radii.
    add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);
    add_cmd(CmdStart, 0, 0, 0, 1'b0);
    add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);
    add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);
    add_cmd(CmdStart, 2047, 2047, 1023, 1'b0);
    for (i = 0; i < 3; i++)
      add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);
    add_cmd(CmdStart, 0, 0, 1023, 1'b0);
    add_cmd(CmdStep, 2047, 2047, 1023, 1'b0);
    add_cmd(CmdStep, 0, 0, 0, 1'b0);
    add_cmd(CmdStart, 1024, 1023, 1, 1'b0);
    add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);
    add_cmd(CmdStart, 2047, 0, 2, 1'b1);
    for (i = 0; i < 3; i++)
      add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);

    // Random circles: mostly small radii walked to completion, some cut short
    // by the next start, with stray commands mixed in.
    seq = 0;
    made = 0;
    while (made < 190) begin
      if ($urandom_range(0, 6) == 0) begin
        add_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, 1'b0);
        made++;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 12)      r = $urandom_range(0, 15);
        else if (sel < 17) r = $urandom_range(16, 100);
        else if (sel < 19) r = $urandom_range(0, 1023);
        else               r = 1023;
        if ($urandom_range(0, 7) == 0) begin
          cx = $urandom_range(0, 1) ? 2047 : 0;
          cy = $urandom_range(0, 1) ? 2047 : 0;
        end else begin
          cx = $urandom_range(0, 2047);
          cy = $urandom_range(0, 2047);
        end
        add_cmd(CmdStart, cx, cy, r, (seq % 6 == 0));
        made++;
        full = r * 707 / 1000 + 2;
        if (r <= 40 && $urandom_range(0, 9) < 7)
          nsteps = full;
        else
          nsteps = $urandom_range(1, (full < 25) ? full : 25);
        for (i = 0; i < nsteps; i++)
          add_cmd(CmdStep, $urandom, $urandom, $urandom, 1'b0);
        made += nsteps;
        seq++;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Drain: everything sent, every predicted point seen, then a margin for
    // stray output beats.
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || in_valid || pixel_q.size() != 0);
    repeat (32) @(posedge clk_i);

    $display("run: %0d circles started, %0d steps traced, %0d steps dropped while idle",
             n_starts, n_steps, n_idle_steps);
    $display("run: %0d circles completed, %0d points checked, %0d mismatches",
             n_circles, n_points, err_cnt);
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mcpg_pkg.sv
hw/rtl/mcpg_front.sv
hw/rtl/mcpg_queue.sv
hw/rtl/mcpg_back.sv
hw/rtl/midpoint_circle_point_generator.sv
bench/tb_top.sv
